// ===== rtl/core/bbls_pkg.sv =====
// Shared types and codes for the byte-budget LRU store.
package bbls_pkg;
   localparam int REQ_BITS = 2;
   localparam int STATUS_BITS = 3;
   localparam int BUDGET_BITS = 40;
   localparam int MAXOBJ_BITS = 24;
   localparam int STAMP_BITS = 48;
   localparam int TOTAL_BITS = 41;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 40;

   localparam logic [REQ_BITS-1:0] REQ_STORE = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_LOAD = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_INVAL = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_HIT = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_MISS = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_STORED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_REJECTED = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_REMOVED = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_EVICTED = 3'd6;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BUDGET = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAXOBJ = 1'b1;

   // Commands from controller to datapath.
   typedef struct packed {
      logic scan_start;   // clear scan results, start from entry 0
      logic scan_step;    // examine the current entry
      logic write_entry;  // write the request into the chosen slot
      logic refresh;      // restamp the hit slot
      logic drop_hit;     // invalidate the hit slot
      logic drop_victim;  // invalidate the victim slot
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic scan_done;
      logic hit;
      logic has_free;
      logic has_victim;
      logic over_budget;
      logic size_bad;
   } stat_type;
endpackage

// ===== rtl/core/bbls_if.sv =====
// Valid/ready channel interfaces for requests, responses and CSR writes.
interface bbls_req_if #(parameter int KEY_BITS = 32, parameter int SIZE_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [KEY_BITS-1:0]  obj_key;
   logic [SIZE_BITS-1:0] obj_size;
   modport source (output valid, req_type, obj_key, obj_size, input ready);
   modport sink (input valid, req_type, obj_key, obj_size, output ready);
endinterface

interface bbls_rsp_if #(parameter int KEY_BITS = 32, parameter int SIZE_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic [2:0]           status;
   logic [KEY_BITS-1:0]  evict_key;
   logic [SIZE_BITS-1:0] evict_size;
   logic                 last;
   modport source (output valid, status, evict_key, evict_size, last, input ready);
   modport sink (input valid, status, evict_key, evict_size, last, output ready);
endinterface

interface bbls_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [39:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bbls_datapath.sv =====
// Entry table, scan unit, byte total and access clock.
module bbls_datapath
   import bbls_pkg::*;
#(
   parameter int ENTRIES = 32,
   parameter int KEY_BITS = 32,
   parameter int SIZE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [KEY_BITS-1:0]    key,
   input  logic [SIZE_BITS-1:0]   size,
   input  logic [BUDGET_BITS-1:0] budget,
   input  logic [MAXOBJ_BITS-1:0] max_obj,
   output logic [KEY_BITS-1:0]    victim_key,
   output logic [SIZE_BITS-1:0]   victim_size
);
   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam logic [STAMP_BITS-1:0] CLOCK_MAX = '1;
   localparam int TB = (SIZE_BITS + IDX_BITS + 1 > TOTAL_BITS) ?
                       SIZE_BITS + IDX_BITS + 1 : TOTAL_BITS;

   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_BITS-1:0]   key_mem [ENTRIES];
   logic [SIZE_BITS-1:0]  size_mem [ENTRIES];
   logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
   logic [TB-1:0]         total_ff;
   logic [STAMP_BITS-1:0] clock_ff;

   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  hit_ff, free_ff, vic_ff;
   logic [IDX_BITS-1:0]   hit_idx_ff, free_idx_ff, vic_idx_ff;
   logic [KEY_BITS-1:0]   vic_key_ff;
   logic [SIZE_BITS-1:0]  vic_size_ff;
   logic [STAMP_BITS-1:0] vic_stamp_ff;

   logic [IDX_BITS-1:0]   cur;
   logic [IDX_BITS-1:0]   slot;
   logic [STAMP_BITS-1:0] next_clock;

   assign cur = cnt_ff[IDX_BITS-1:0];
   assign next_clock = (clock_ff == CLOCK_MAX) ? clock_ff : clock_ff + 1'b1;
   assign slot = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : vic_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         total_ff <= '0;
         clock_ff <= '0;
         cnt_ff <= '0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
         vic_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            cnt_ff <= '0;
            hit_ff <= 1'b0;
            free_ff <= 1'b0;
            vic_ff <= 1'b0;
         end else if (cmd.scan_step && cnt_ff != CNT_BITS'(ENTRIES)) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (valid_ff[cur]) begin
               if (!hit_ff && key_mem[cur] == key) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= cur;
               end
               if (!vic_ff || (stamp_mem[cur] < vic_stamp_ff) ||
                   (stamp_mem[cur] == vic_stamp_ff && key_mem[cur] < vic_key_ff)) begin
                  vic_ff <= 1'b1;
                  vic_idx_ff <= cur;
                  vic_key_ff <= key_mem[cur];
                  vic_size_ff <= size_mem[cur];
                  vic_stamp_ff <= stamp_mem[cur];
               end
            end else if (!free_ff) begin
               free_ff <= 1'b1;
               free_idx_ff <= cur;
            end
         end else if (cmd.drop_victim) begin
            // The slot of a victim dropped for a full table takes the new entry.
            free_ff <= 1'b1;
            free_idx_ff <= vic_idx_ff;
         end
         if (cmd.write_entry) begin
            // Replace: remove old size; full-table victim is dropped separately.
            valid_ff[slot] <= 1'b1;
            key_mem[slot] <= key;
            size_mem[slot] <= size;
            stamp_mem[slot] <= next_clock;
            clock_ff <= next_clock;
            total_ff <= total_ff + TB'(size) -
                        (hit_ff ? TB'(size_mem[hit_idx_ff]) : TB'(0));
         end else if (cmd.refresh) begin
            stamp_mem[hit_idx_ff] <= next_clock;
            clock_ff <= next_clock;
         end else if (cmd.drop_hit) begin
            valid_ff[hit_idx_ff] <= 1'b0;
            total_ff <= total_ff - TB'(size_mem[hit_idx_ff]);
         end else if (cmd.drop_victim) begin
            valid_ff[vic_idx_ff] <= 1'b0;
            total_ff <= total_ff - TB'(vic_size_ff);
         end
      end
   end

   assign stat.scan_done = (cnt_ff == CNT_BITS'(ENTRIES));
   assign stat.hit = hit_ff;
   assign stat.has_free = free_ff;
   assign stat.has_victim = vic_ff;
   assign stat.over_budget = total_ff > TB'(budget);
   assign stat.size_bad = (size == '0) || (TB'(size) > TB'(max_obj));
   assign victim_key = vic_key_ff;
   assign victim_size = vic_size_ff;
endmodule

// ===== rtl/core/bbls_ctrl.sv =====
// Request sequencer: scans, evictions and response words.
module bbls_ctrl
   import bbls_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic [REQ_BITS-1:0]    req_kind,
   output logic                   busy,
   input  stat_type               stat,
   output cmd_type                cmd,
   output logic                   out_load,
   output logic                   out_evict,
   output logic [STATUS_BITS-1:0] out_status,
   input  logic                   out_free
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_FULLEV = 3'd3;
   localparam logic [2:0] S_BSCAN = 3'd4;
   localparam logic [2:0] S_BCHECK = 3'd5;
   localparam logic [2:0] S_BEVICT = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [REQ_BITS-1:0]   kind_ff, kind_in;
   logic [STATUS_BITS-1:0] fin_ff, fin_in;

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff <= REQ_STORE;
         fin_ff <= ST_REJECTED;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         fin_ff <= fin_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      fin_in = fin_ff;
      cmd = '0;
      out_load = 1'b0;
      out_evict = 1'b0;
      out_status = fin_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in = req_kind;
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_DONE;
            priority case (kind_ff)
               REQ_STORE: begin
                  if (stat.size_bad) fin_in = ST_REJECTED;
                  else if (!stat.hit && !stat.has_free) state_in = S_FULLEV;
                  else begin
                     cmd.write_entry = 1'b1;
                     fin_in = ST_STORED;
                     state_in = S_BSCAN;
                  end
               end
               REQ_LOAD: begin
                  fin_in = stat.hit ? ST_HIT : ST_MISS;
                  cmd.refresh = stat.hit;
               end
               REQ_INVAL: begin
                  fin_in = stat.hit ? ST_REMOVED : ST_NOTFOUND;
                  cmd.drop_hit = stat.hit;
               end
               default: fin_in = ST_REJECTED;
            endcase
            if (state_in == S_BSCAN) cmd.scan_start = 1'b1;
         end
         S_FULLEV: begin
            // Report and drop the LRU entry, then write into its slot.
            if (out_free) begin
               out_load = 1'b1;
               out_evict = 1'b1;
               cmd.drop_victim = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_BSCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = S_BCHECK;
         end
         S_BCHECK: begin
            if (stat.over_budget && stat.has_victim) state_in = S_BEVICT;
            else state_in = S_DONE;
         end
         S_BEVICT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_evict = 1'b1;
               cmd.drop_victim = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = S_BSCAN;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== rtl/core/byte_budget_lru_store.sv =====
// Top level of the byte-budget LRU store.
// The block keeps a directory of ENTRIES cached objects named by tags.
// Requests arrive as words on req (store, load or invalidate). Config
// registers are written through csr; the user must write them only while
// the block is idle, as the block itself does not enforce it. Each request
// gives one or more response words on rsp. Evictions come as status-evicted
// words with last low; the final word of a request has last high.
// Every request first scans the table, one entry per cycle. A store that
// is written runs a second scan to check the budget, and each budget
// eviction starts that scan again; a full-table eviction adds an evicted
// word before the write. One request is in flight at a time: a new request
// is taken only once the final word has been loaded into the response
// register, so the entry-by-entry table scan sets the request rate.
// A response register holds each word until it is taken; when rsp stalls
// the sequencer waits for the register to empty. Synchronous reset empties
// the table, clears the byte total and access clock and loads the default
// budget and object limit.
module byte_budget_lru_store
   import bbls_pkg::*;
#(
   parameter int ENTRIES = 32,
   parameter int KEY_BITS = 32,
   parameter int SIZE_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   bbls_req_if.sink   req,
   bbls_rsp_if.source rsp,
   bbls_csr_if.sink   csr
);
   logic [BUDGET_BITS-1:0] budget_ff;
   logic [MAXOBJ_BITS-1:0] maxobj_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [SIZE_BITS-1:0]   size_ff;

   cmd_type  cmd;
   stat_type stat;
   logic busy, out_load, out_evict, out_free;
   logic [STATUS_BITS-1:0] out_status;
   logic [KEY_BITS-1:0]    vic_key;
   logic [SIZE_BITS-1:0]   vic_size;

   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [KEY_BITS-1:0]    rsp_key_ff;
   logic [SIZE_BITS-1:0]   rsp_size_ff;
   logic                   rsp_last_ff;

   assign req.ready = !busy;
   assign csr.ready = 1'b1;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Configuration registers and the captured request payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_BITS'(40'd1073741824);
         maxobj_ff <= '1;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_BUDGET: budget_ff <= csr.data;
            CSR_MAXOBJ: maxobj_ff <= csr.data[MAXOBJ_BITS-1:0];
            default: ;
         endcase
      end
      if (req.valid && !busy) begin
         key_ff <= req.obj_key;
         size_ff <= req.obj_size;
      end
   end

   // Output register: one word held until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_status_ff <= out_evict ? ST_EVICTED : out_status;
         rsp_key_ff <= out_evict ? vic_key : '0;
         rsp_size_ff <= out_evict ? vic_size : '0;
         rsp_last_ff <= !out_evict;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.evict_key = rsp_key_ff;
   assign rsp.evict_size = rsp_size_ff;
   assign rsp.last = rsp_last_ff;

   bbls_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req.valid && !busy), .req_kind(req.req_type),
      .busy(busy), .stat(stat), .cmd(cmd),
      .out_load(out_load), .out_evict(out_evict), .out_status(out_status),
      .out_free(out_free)
   );

   bbls_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .SIZE_BITS(SIZE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .key(key_ff), .size(size_ff), .budget(budget_ff), .max_obj(maxobj_ff),
      .victim_key(vic_key), .victim_size(vic_size)
   );
endmodule

// ===== rtl/core/bbls_checker.sv =====
// Port-level checks for the byte-budget LRU store, bound to the top level.
module bbls_checker
   import bbls_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response word dropped while stalled");
   a_evict_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_EVICTED) != rsp_last))
      else $error("last flag disagrees with status");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken during work");
   a_no_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_last)
      else $error("eviction word shown while idle");
endmodule

bind byte_budget_lru_store bbls_checker u_bbls_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_last(rsp.last)
);

// ===== test/bbls_tb_pkg.sv =====
// Testbench-side types for the byte-budget LRU store bench.
`timescale 1ns / 1ps
package bbls_tb_pkg;
   import bbls_pkg::*;

   // One request word as the driver presents it.
   typedef struct {
      logic [REQ_BITS-1:0] kind;
      logic [31:0]         key;
      logic [23:0]         size;
   } request_type;

   // One response word as the monitor expects it.
   typedef struct {
      logic [STATUS_BITS-1:0] status;
      logic [31:0]            key;
      logic [23:0]            size;
      logic                   last;
   } reply_type;
endpackage

// ===== test/testbench.sv =====
// Self-checking bench for the byte-budget LRU store: directed and random requests.
`timescale 1ns / 1ps
module testbench;
   import bbls_pkg::*;
   import bbls_tb_pkg::*;

   localparam int SLOTS = 32;
   localparam logic [47:0] CLOCK_TOP = 48'hFFFF_FFFF_FFFF;
   localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   bbls_req_if req ();
   bbls_rsp_if rsp ();
   bbls_csr_if csr ();

   byte_budget_lru_store dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   // Shadow copy of the directory. The predictor walks it the same way the
   // hardware walks its table, so eviction order is fully determined.
   logic        slot_used [SLOTS];
   logic [31:0] slot_key [SLOTS];
   logic [23:0] slot_size [SLOTS];
   logic [47:0] slot_stamp [SLOTS];
   logic [40:0] resident_bytes;
   logic [47:0] access_count;
   logic [39:0] budget;
   logic [23:0] max_object;

   request_type pending_requests[$];
   reply_type   expected_replies[$];
   int          failures = 0;

   // Slot of a valid entry with this key, or -1.
   function automatic int lookup_slot(logic [31:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
   endfunction

   // Least recent valid entry; equal stamps go to the lower key.
   function automatic int oldest_slot();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_used[i]) continue;
         if (best < 0 || slot_stamp[i] < slot_stamp[best] ||
             (slot_stamp[i] == slot_stamp[best] && slot_key[i] < slot_key[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic void push_reply(logic [2:0] st, logic [31:0] k,
                                      logic [23:0] s, logic l);
      reply_type r;
      r.status = st;
      r.key = k;
      r.size = s;
      r.last = l;
      expected_replies = {expected_replies, r};
   endfunction

   function automatic void drop_oldest(int v);
      push_reply(ST_EVICTED, slot_key[v], slot_size[v], 1'b0);
      resident_bytes -= 41'(slot_size[v]);
      slot_used[v] = 1'b0;
   endfunction

   function automatic logic [47:0] next_stamp();
      if (access_count < CLOCK_TOP) access_count++;
      return access_count;
   endfunction

   // Works out every response word one accepted request causes.
   function automatic void predict_replies(request_type q);
      int slot;
      int v;
      if (q.kind == REQ_STORE) begin
         if (q.size == 0 || q.size > max_object) begin
            push_reply(ST_REJECTED, '0, '0, 1'b1);
            return;
         end
         slot = lookup_slot(q.key);
         if (slot >= 0) begin
            resident_bytes -= 41'(slot_size[slot]);
         end else begin
            for (int i = 0; i < SLOTS; i++)
               if (!slot_used[i]) begin
                  slot = i;
                  break;
               end
            if (slot < 0) begin
               slot = oldest_slot();
               drop_oldest(slot);
            end
         end
         slot_used[slot] = 1'b1;
         slot_key[slot] = q.key;
         slot_size[slot] = q.size;
         slot_stamp[slot] = next_stamp();
         resident_bytes += 41'(q.size);
         while (resident_bytes > {1'b0, budget}) begin
            v = oldest_slot();
            if (v < 0) break;
            drop_oldest(v);
         end
         push_reply(ST_STORED, '0, '0, 1'b1);
      end else if (q.kind == REQ_LOAD) begin
         slot = lookup_slot(q.key);
         if (slot >= 0) begin
            slot_stamp[slot] = next_stamp();
            push_reply(ST_HIT, '0, '0, 1'b1);
         end else begin
            push_reply(ST_MISS, '0, '0, 1'b1);
         end
      end else if (q.kind == REQ_INVAL) begin
         slot = lookup_slot(q.key);
         if (slot >= 0) begin
            resident_bytes -= 41'(slot_size[slot]);
            slot_used[slot] = 1'b0;
            push_reply(ST_REMOVED, '0, '0, 1'b1);
         end else begin
            push_reply(ST_NOTFOUND, '0, '0, 1'b1);
         end
      end else begin
         // The unused request code is answered as a rejection.
         push_reply(ST_REJECTED, '0, '0, 1'b1);
      end
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Driver: presents queued words, idling a random number of cycles
   // between them. Acceptance is seen on the edge and feeds the predictor.
   int send_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.req_type <= REQ_STORE;
         req.obj_key <= '0;
         req.obj_size <= '0;
      end else begin
         if (req.valid && req.ready) begin
            predict_replies('{req.req_type, req.obj_key, req.obj_size});
            send_wait = gap_length();
         end
         if ((req.valid && req.ready) || !req.valid) begin
            if (send_wait > 0 || pending_requests.size() == 0) begin
               if (send_wait > 0) send_wait--;
               req.valid <= 1'b0;
            end else begin
               request_type q;
               q = pending_requests.pop_front();
               req.valid <= 1'b1;
               req.req_type <= q.kind;
               req.obj_key <= q.key;
               req.obj_size <= q.size;
            end
         end
      end
   end

   // Monitor: randomly stalls the response side and checks every word taken.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_replies.size() == 0) begin
               $error("unexpected response word, status %0d", rsp.status);
               failures++;
            end else begin
               reply_type e;
               e = expected_replies.pop_front();
               if (rsp.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp.status);
                  failures++;
               end
               if (rsp.evict_key !== e.key) begin
                  $error("evict_key: expected %h, got %h", e.key, rsp.evict_key);
                  failures++;
               end
               if (rsp.evict_size !== e.size) begin
                  $error("evict_size: expected %h, got %h", e.size, rsp.evict_size);
                  failures++;
               end
               if (rsp.last !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp.last);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = gap_length();
         end
      end
   end

   // Writes one register. The block must be idle, so callers drain first.
   task automatic write_register(logic [0:0] index, logic [39:0] value);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (index == CSR_BUDGET) budget = value;
      else max_object = value[23:0];
   endtask

   // Waits until every queued word is out and answered, then lets the
   // block finish any scan it might still be in.
   task automatic drain();
      wait (pending_requests.size() == 0 && !req.valid);
      wait (expected_replies.size() == 0);
      repeat (4 * SLOTS) @(posedge clock);
   endtask

   function automatic void queue_request(logic [1:0] kind, logic [31:0] key,
                                         logic [23:0] size);
      request_type q;
      q.kind = kind;
      q.key = key;
      q.size = size;
      pending_requests = {pending_requests, q};
   endfunction

   // Keys come from a small pool most of the time so that hits, replacement
   // and invalidates of live entries are common.
   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return 32'h1000 + $urandom_range(0, 47);
   endfunction

   function automatic logic [23:0] pick_size(logic [23:0] cap);
      case ($urandom_range(0, 9))
         0: return 24'd0;
         1: return 24'($urandom());
         2: return cap;
         default: return 24'($urandom_range(1, 4096));
      endcase
   endfunction

   task automatic random_phase(int count, logic [23:0] cap);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 19);
         if (r < 10) queue_request(REQ_STORE, pick_key(), pick_size(cap));
         else if (r < 15) queue_request(REQ_LOAD, pick_key(), pick_size(cap));
         else if (r < 19) queue_request(REQ_INVAL, pick_key(), pick_size(cap));
         else queue_request(REQ_UNUSED, $urandom(), 24'($urandom()));
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_key[i] = '0;
         slot_size[i] = '0;
         slot_stamp[i] = '0;
      end
      resident_bytes = '0;
      access_count = '0;
      budget = 40'd1073741824;
      max_object = 24'hFF_FFFF;
      req.valid = 1'b0;
      req.req_type = REQ_STORE;
      req.obj_key = '0;
      req.obj_size = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = CSR_BUDGET;
      csr.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words at reset settings: field extremes, every request code.
      queue_request(REQ_STORE, 32'h0, 24'd0);             // zero size is rejected
      queue_request(REQ_STORE, 32'hFFFF_FFFF, 24'hFF_FFFF);
      queue_request(REQ_STORE, 32'h0, 24'd1);
      queue_request(REQ_LOAD, 32'hFFFF_FFFF, 24'hFF_FFFF);
      queue_request(REQ_LOAD, 32'h1234_5678, 24'd0);      // miss
      queue_request(REQ_STORE, 32'h0, 24'd77);            // replace in place
      queue_request(REQ_INVAL, 32'h0, 24'd0);
      queue_request(REQ_INVAL, 32'h0, 24'd0);             // not found
      queue_request(REQ_UNUSED, 32'hFFFF_FFFF, 24'hFF_FFFF);
      drain();

      // A tight budget forces evictions, including of the new word itself.
      write_register(CSR_BUDGET, 40'd100);
      write_register(CSR_MAXOBJ, 40'd200);
      queue_request(REQ_STORE, 32'h2000, 24'd60);
      queue_request(REQ_STORE, 32'h2001, 24'd30);
      queue_request(REQ_LOAD, 32'h2000, 24'd0);
      queue_request(REQ_STORE, 32'h2002, 24'd50);         // evicts both older entries
      queue_request(REQ_STORE, 32'h2003, 24'd150);        // evicts all, then itself
      queue_request(REQ_STORE, 32'h2004, 24'd201);        // above the object limit
      drain();

      // Fill past the table size so the full-table eviction path runs.
      write_register(CSR_BUDGET, 40'hFF_FFFF_FFFF);
      write_register(CSR_MAXOBJ, 40'hFF_FFFF);
      for (int i = 0; i < SLOTS + 4; i++)
         queue_request(REQ_STORE, 32'h3000 - i, 24'hFF_FFFF);
      drain();

      // A zero object limit rejects every store; zero budget evicts all.
      write_register(CSR_MAXOBJ, 40'd0);
      queue_request(REQ_STORE, 32'h5, 24'd1);
      drain();
      write_register(CSR_BUDGET, 40'd0);
      write_register(CSR_MAXOBJ, 40'hFF_FFFF);
      queue_request(REQ_STORE, 32'h6, 24'd9);
      drain();

      // Random phases under several limits.
      write_register(CSR_BUDGET, 40'd20000);
      write_register(CSR_MAXOBJ, 40'd4096);
      random_phase(50, 24'd4096);
      drain();
      write_register(CSR_BUDGET, 40'd1073741824);
      write_register(CSR_MAXOBJ, 40'hFF_FFFF);
      random_phase(40, 24'hFF_FFFF);
      drain();
      write_register(CSR_BUDGET, 40'd3000);
      write_register(CSR_MAXOBJ, 40'd1500);
      random_phase(50, 24'd1500);
      wait (pending_requests.size() == 0 && !req.valid);
      wait (expected_replies.size() == 0);
      repeat (4 * SLOTS) @(posedge clock);

      if (failures == 0 && expected_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/bbls_pkg.sv
rtl/core/bbls_if.sv
rtl/core/bbls_datapath.sv
rtl/core/bbls_ctrl.sv
rtl/core/byte_budget_lru_store.sv
rtl/core/bbls_checker.sv
test/bbls_tb_pkg.sv
test/testbench.sv
